// ===== sv/msort_pkg.sv =====
// ----------------------------------------------------------------------------
// msort_pkg
// Shared constants and controller/datapath types for the merge sorter.
// ----------------------------------------------------------------------------
package msort_pkg;

   localparam int DATA_W        = 32;
   localparam int MAX_ITEMS_DEF = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_GAP,
      ST_MERGE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic merge;
      logic out_step;
   } cmd_type;

   typedef struct packed {
      logic pass_end;
      logic sorted;
      logic out_room;
      logic out_last;
   } status_type;

endpackage

// ===== sv/msort_ctrl.sv =====
// ----------------------------------------------------------------------------
// msort_ctrl
// Sequencer for the merge sorter: load, merge passes, then output burst.
// ----------------------------------------------------------------------------
module msort_ctrl import msort_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_is_last,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_is_last) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_GAP;
         end
         // gap state: lets the read registers pick up the new pass start
         ST_GAP: begin
            state_in = status.sorted ? ST_OUT : ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.pass_end) begin
               state_in = ST_GAP;
            end
         end
         ST_OUT: begin
            if (status.out_room) begin
               cmd.out_step = 1'b1;
               if (status.out_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/msort_dp.sv =====
// ----------------------------------------------------------------------------
// msort_dp
// Ping-pong buffers, merge pointers and output register of the merge sorter.
// ----------------------------------------------------------------------------
module msort_dp import msort_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_last_out,
   output logic                     rsp_overflowed
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int SUM_W = CNT_W + 2;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

   logic signed [DATA_W-1:0] buf_a_ff [MAX_ITEMS];
   logic signed [DATA_W-1:0] buf_b_ff [MAX_ITEMS];
   logic signed [DATA_W-1:0] rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [SUM_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             src_sel_ff, src_sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic             rsp_last_ff, rsp_ovf_ff;

   logic signed [DATA_W-1:0] src_i, src_j, wr_data;
   logic             wr_a, wr_b;
   logic [IDX_W-1:0] wr_addr;
   logic             take_left, run_end, last_run, out_last;
   logic [SUM_W-1:0] w2;

   function automatic logic [CNT_W-1:0] sat_cnt(input logic [SUM_W-1:0] sum,
                                                input logic [CNT_W-1:0] lim);
      if (sum > SUM_W'(lim)) begin
         return lim;
      end else begin
         return sum[CNT_W-1:0];
      end
   endfunction

   assign src_i     = src_sel_ff ? rd_b0_ff : rd_a0_ff;
   assign src_j     = src_sel_ff ? rd_b1_ff : rd_a1_ff;
   // left run wins ties
   assign take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (src_i <= src_j));
   assign run_end   = (SUM_W'(k_ff) + SUM_W'(1)) == SUM_W'(hi_ff);
   assign last_run  = hi_ff == count_ff;
   assign w2        = width_ff << 1;
   assign out_last  = (SUM_W'(i_ff) + SUM_W'(1)) == SUM_W'(count_ff);

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      width_in     = width_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      src_sel_in   = src_sel_ff;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      wr_addr      = k_ff[IDX_W-1:0];
      wr_data      = take_left ? src_i : src_j;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         if (count_ff < MAX_CNT) begin
            wr_a     = 1'b1;
            wr_addr  = count_ff[IDX_W-1:0];
            wr_data  = req_value;
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.prep) begin
         width_in   = SUM_W'(1);
         mid_in     = sat_cnt(SUM_W'(1), count_ff);
         hi_in      = sat_cnt(SUM_W'(2), count_ff);
         i_in       = '0;
         j_in       = sat_cnt(SUM_W'(1), count_ff);
         k_in       = '0;
         src_sel_in = 1'b0;
      end

      if (cmd.merge) begin
         wr_a = src_sel_ff;
         wr_b = !src_sel_ff;
         if (take_left) begin
            i_in = i_ff + CNT_W'(1);
         end else begin
            j_in = j_ff + CNT_W'(1);
         end
         k_in = k_ff + CNT_W'(1);
         if (run_end) begin
            if (last_run) begin
               // pass finished: double the run width and swap buffers
               width_in   = w2;
               mid_in     = sat_cnt(w2, count_ff);
               hi_in      = sat_cnt(w2 << 1, count_ff);
               i_in       = '0;
               j_in       = sat_cnt(w2, count_ff);
               k_in       = '0;
               src_sel_in = !src_sel_ff;
            end else begin
               mid_in = sat_cnt(SUM_W'(hi_ff) + width_ff, count_ff);
               hi_in  = sat_cnt(SUM_W'(hi_ff) + w2, count_ff);
               i_in   = hi_ff;
               j_in   = sat_cnt(SUM_W'(hi_ff) + width_ff, count_ff);
               k_in   = hi_ff;
            end
         end
      end

      if (cmd.out_step) begin
         rsp_valid_in = 1'b1;
         i_in         = i_ff + CNT_W'(1);
         if (out_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_sel_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         src_sel_ff   <= src_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      if (cmd.out_step) begin
         rsp_value_ff <= src_i;
         rsp_last_ff  <= out_last;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // read data follows the next pointer values, so it is current in the cycle after
   always_ff @(posedge clock) begin
      if (wr_a) begin
         buf_a_ff[wr_addr] <= wr_data;
      end
      rd_a0_ff <= buf_a_ff[i_in[IDX_W-1:0]];
      rd_a1_ff <= buf_a_ff[j_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         buf_b_ff[wr_addr] <= wr_data;
      end
      rd_b0_ff <= buf_b_ff[i_in[IDX_W-1:0]];
      rd_b1_ff <= buf_b_ff[j_in[IDX_W-1:0]];
   end

   assign status.pass_end = run_end && last_run;
   assign status.sorted   = width_ff >= SUM_W'(count_ff);
   assign status.out_room = !rsp_valid_ff || !rsp_stall;
   assign status.out_last = out_last;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule

// ===== sv/merge_sorter_core.sv =====
// ----------------------------------------------------------------------------
// merge_sorter_core
// Bottom-up merge sort of one list of signed 32-bit values.
// ----------------------------------------------------------------------------
// The req channel carries one list element per transfer; req_is_last closes
// the list. Elements past MAX_ITEMS are dropped and every result of that list
// then has rsp_overflowed set. After the closing transfer the block stalls
// req, sorts ascending (stable, left run first on ties) and sends the n
// sorted values on the rsp channel, rsp_last_out marking the final one.
// Phases for a list of n stored values:
//   load     1 cycle per element
//   sort     prep and gap setup states, then ceil(log2 n) passes, each ending in a gap;
//            one merged element per cycle through two ping-pong buffers
//            with two registered read ports each
//   output   1 value per cycle while rsp_stall is low
// A held rsp_stall freezes the output register and pauses the burst; the
// next list may start loading while the final result still waits.
// Reset empties the list and clears the output valid flag; buffer contents
// are not cleared, as only written entries are ever used.
// ----------------------------------------------------------------------------
module merge_sorter_core import msort_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_last_out,
   output logic                     rsp_overflowed
);

   cmd_type    cmd;
   status_type status;

   msort_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   msort_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for merge_sorter_core: lists of signed values are loaded
// over req, a local sorter predicts the ascending burst of each list and the
// rsp transfers are compared field by field, with random idle on both sides.
// ----------------------------------------------------------------------------
module tb import msort_pkg::*; ();

   localparam int CAPACITY    = MAX_ITEMS_DEF;
   localparam int ITEM_TARGET = 410;
   localparam int GAP_PCT     = 28;

   typedef enum int {VAL_FULL, VAL_NARROW, VAL_EDGE} value_kind_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     ovf;
   } sorted_entry_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     req_is_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_last_out;
   logic                     rsp_overflowed;

   // list being loaded, as the block should hold it
   logic signed [DATA_W-1:0] pending_list_q[$];
   logic                     pending_ovf = 1'b0;
   sorted_entry_type         sorted_expect_q[$];
   sorted_entry_type         head;
   int                       errors = 0;
   int                       elements_sent = 0;
   bit                       steady = 1'b0;

   merge_sorter_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflowed   (rsp_overflowed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // store one accepted element; on the closing one, queue the sorted burst
   function automatic void record_element(input logic signed [DATA_W-1:0] v,
                                          input logic l);
      logic signed [DATA_W-1:0] ordered_q[$];
      sorted_entry_type         e;
      int                       pos;
      if (pending_list_q.size() < CAPACITY)
         pending_list_q.push_back(v);
      else
         pending_ovf = 1'b1;
      if (l) begin
         // stable insertion: equal values stay in arrival order
         foreach (pending_list_q[i]) begin
            pos = ordered_q.size();
            while (pos > 0 && ordered_q[pos-1] > pending_list_q[i])
               pos--;
            ordered_q.insert(pos, pending_list_q[i]);
         end
         foreach (ordered_q[i]) begin
            e.value = ordered_q[i];
            e.last  = (i == ordered_q.size() - 1);
            e.ovf   = pending_ovf;
            sorted_expect_q.push_back(e);
         end
         pending_list_q.delete();
         pending_ovf = 1'b0;
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value(input value_kind_type kind);
      logic signed [DATA_W-1:0] v;
      case (kind)
         VAL_NARROW: begin
            v = int'($urandom_range(0, 8)) - 4;
         end
         VAL_EDGE: begin
            case ($urandom_range(0, 5))
               0: v = 32'sh8000_0000;
               1: v = 32'sh8000_0001;
               2: v = 32'sh7FFF_FFFF;
               3: v = 32'sh7FFF_FFFE;
               4: v = 0;
               default: v = -1;
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   // entered and left at a falling edge; valid stays up for a following transfer
   task automatic push_element(input logic signed [DATA_W-1:0] v, input logic l);
      while (!steady && $urandom_range(0, 99) < GAP_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= v;
      req_is_last <= l;
      do
         @(posedge clock);
      while (req_stall);
      record_element(v, l);
      elements_sent++;
      @(negedge clock);
   endtask

   task automatic send_list(input int len, input value_kind_type kind);
      for (int i = 0; i < len; i++)
         push_element(pick_value(kind), i == len - 1);
   endtask

   task automatic test_single_values();
      push_element(32'sh7FFF_FFFF, 1'b1);
      push_element(32'sh8000_0000, 1'b1);
   endtask

   task automatic test_extremes();
      push_element(0, 1'b0);
      push_element(32'sh7FFF_FFFF, 1'b0);
      push_element(-1, 1'b0);
      push_element(32'sh8000_0000, 1'b0);
      push_element(1, 1'b1);
   endtask

   task automatic test_ties();
      push_element(5, 1'b0);
      push_element(-5, 1'b0);
      push_element(5, 1'b0);
      push_element(5, 1'b0);
      push_element(-5, 1'b0);
      push_element(0, 1'b1);
   endtask

   task automatic test_ordered_inputs();
      push_element(3, 1'b0);
      push_element(2, 1'b0);
      push_element(1, 1'b1);
      push_element(1, 1'b0);
      push_element(2, 1'b0);
      push_element(3, 1'b1);
   endtask

   // full list, then the closing element dropped, then several dropped
   task automatic test_capacity();
      send_list(CAPACITY, VAL_FULL);
      send_list(CAPACITY + 1, VAL_NARROW);
      send_list(CAPACITY + 3, VAL_FULL);
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      for (int i = 0; i < 8; i++)
         send_list($urandom_range(1, 8), value_kind_type'($urandom_range(0, 2)));
      steady = 1'b0;
   endtask

   task automatic test_random_lists();
      int r;
      int len;
      while (elements_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            len = $urandom_range(1, 8);
         else if (r < 92)
            len = $urandom_range(9, 32);
         else
            len = $urandom_range(33, CAPACITY);
         send_list(len, value_kind_type'($urandom_range(0, 2)));
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < GAP_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_expect_q.size() == 0) begin
            $display("%0t unexpected transfer: value %0d last %0b ovf %0b", $time,
                     rsp_sorted_value, rsp_last_out, rsp_overflowed);
            errors++;
         end else begin
            head = sorted_expect_q.pop_front();
            if (rsp_sorted_value !== head.value) begin
               $display("%0t sorted_value: expected %0d, actual %0d", $time,
                        head.value, rsp_sorted_value);
               errors++;
            end
            if (rsp_last_out !== head.last) begin
               $display("%0t last_out: expected %0b, actual %0b", $time,
                        head.last, rsp_last_out);
               errors++;
            end
            if (rsp_overflowed !== head.ovf) begin
               $display("%0t overflowed: expected %0b, actual %0b", $time,
                        head.ovf, rsp_overflowed);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_values();
      test_extremes();
      test_ties();
      test_ordered_inputs();
      test_capacity();
      test_back_to_back();
      test_random_lists();
      req_valid <= 1'b0;
      while (sorted_expect_q.size() != 0)
         @(posedge clock);
      repeat (700) @(posedge clock);
      if (errors == 0 && sorted_expect_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
